### hw/rtl/aprlm_pkg.sv
// ----------------------------------------------------------------------------
// aprlm_pkg
// shared types and constants of the audio peak / rms level meter
// ----------------------------------------------------------------------------
package aprlm_pkg;

    localparam int SAMPLE_BITS     = 24;
    localparam int LEVEL_W         = SAMPLE_BITS;
    localparam int FRAME_W         = 48;
    localparam int GAIN_W          = 16;
    localparam int GAIN_FRAC       = 12;
    localparam int CHAN_W          = 2;
    localparam int CFG_DATA_W      = 32;
    localparam int CFG_ADDR_W      = 3;
    localparam int REG_IDX_W       = 1;
    localparam int QUEUE_DEPTH     = 8;
    localparam int MAX_BUFFER_SAMPLES_DEFAULT = 4096;

    localparam logic [CHAN_W-1:0] CHANNEL_COUNT_RESET = 2'd1;
    localparam logic [CHAN_W-1:0] CH_STEREO           = 2'd2;
    localparam logic [GAIN_W-1:0] INPUT_GAIN_RESET    = 16'd4096;

    localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_INPUT_GAIN    = 1'b1;

    localparam logic OP_SAMPLE   = 1'b0;
    localparam logic OP_READ     = 1'b1;
    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef struct packed {
        logic                          opcode;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_of_buffer;
    } in_item_t;

    typedef struct packed {
        logic               report_kind;
        logic [LEVEL_W-1:0] current_peak;
        logic [LEVEL_W-1:0] current_rms;
        logic [LEVEL_W-1:0] interval_peak;
        logic [LEVEL_W-1:0] held_peak;
        logic [FRAME_W-1:0] frame_total;
    } report_t;

endpackage

### hw/rtl/aprlm_front.sv
// ----------------------------------------------------------------------------
// aprlm_front
// gain pipeline and per-buffer peak / square-sum accumulation; closes and
// read requests are handed to the back end as jobs
// ----------------------------------------------------------------------------
module aprlm_front
    import aprlm_pkg::*;
#(
    parameter int MAX_BUFFER_SAMPLES = MAX_BUFFER_SAMPLES_DEFAULT,
    parameter int CNT_W              = $clog2(MAX_BUFFER_SAMPLES + 1),
    parameter int SUM_W              = 2 * (SAMPLE_BITS - 1) + 1 + CNT_W,
    parameter int JOB_W              = 1 + LEVEL_W + SUM_W + CNT_W,
    parameter int LVL_W              = $clog2(QUEUE_DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  in_item_t          item,
    input  logic [GAIN_W-1:0] input_gain,
    input  logic [LVL_W-1:0]  q_level,
    output logic              q_push,
    output logic [JOB_W-1:0]  q_wdata
);

    localparam int SQ_W     = 2 * (SAMPLE_BITS - 1) + 1;
    localparam int PROD_W   = SAMPLE_BITS + GAIN_W;
    localparam int SCALED_W = PROD_W - GAIN_FRAC;
    localparam int OCC_W    = LVL_W + 2;
    localparam logic [PROD_W-1:0]  ROUND_HALF = PROD_W'(1) << (GAIN_FRAC - 1);
    localparam logic [LEVEL_W-1:0] MAG_HALF   = LEVEL_W'(1) << (SAMPLE_BITS - 1);

    logic               va_reg, vb_reg, vc_reg;
    in_item_t           a_item_reg;
    logic               b_op_reg, b_last_reg, c_op_reg, c_last_reg;
    logic [LEVEL_W-1:0] b_mag_reg, c_mag_reg;
    logic [SQ_W-1:0]    c_sq_reg;
    logic [LEVEL_W-1:0] run_peak_reg, run_peak_next;
    logic [SUM_W-1:0]   run_sum_reg, run_sum_next;
    logic [CNT_W-1:0]   run_cnt_reg, run_cnt_next;

    logic [LEVEL_W-1:0]  raw_bits, mag_in, lim;
    logic                neg;
    logic [PROD_W-1:0]   prod;
    logic [SCALED_W-1:0] scaled;
    logic [LEVEL_W-1:0]  gained;
    logic [2*LEVEL_W-1:0] square;
    logic [OCC_W-1:0]    occupancy;
    logic                accept, closing;

    assign occupancy = OCC_W'(q_level) + OCC_W'(va_reg) + OCC_W'(vb_reg) + OCC_W'(vc_reg);
    assign full      = occupancy >= OCC_W'(QUEUE_DEPTH);
    assign accept    = push && !full;

    // gain with rounding and saturation
    always_comb
    begin
        raw_bits = a_item_reg.sample;
        neg      = raw_bits[SAMPLE_BITS-1];
        mag_in   = neg ? (~raw_bits + 1'b1) : raw_bits;
        prod     = PROD_W'(mag_in) * PROD_W'(input_gain) + ROUND_HALF;
        scaled   = prod[PROD_W-1:GAIN_FRAC];
        lim      = neg ? MAG_HALF : MAG_HALF - 1'b1;
        gained   = (scaled > SCALED_W'(lim)) ? lim : scaled[LEVEL_W-1:0];
    end

    assign square = b_mag_reg * b_mag_reg;

    // accumulation and job hand-off
    always_comb
    begin
        run_peak_next = run_peak_reg;
        run_sum_next  = run_sum_reg;
        run_cnt_next  = run_cnt_reg;
        closing       = 1'b0;
        q_push        = 1'b0;
        q_wdata       = '0;
        if (vc_reg)
        begin
            if (c_op_reg == OP_READ)
            begin
                q_push  = 1'b1;
                q_wdata = {KIND_READ, LEVEL_W'(0), SUM_W'(0), CNT_W'(0)};
            end
            else
            begin
                run_peak_next = (c_mag_reg > run_peak_reg) ? c_mag_reg : run_peak_reg;
                run_sum_next  = run_sum_reg + SUM_W'(c_sq_reg);
                run_cnt_next  = run_cnt_reg + 1'b1;
                closing       = c_last_reg || (run_cnt_next == CNT_W'(MAX_BUFFER_SAMPLES));
                if (closing)
                begin
                    q_push        = 1'b1;
                    q_wdata       = {KIND_UPDATE, run_peak_next, run_sum_next, run_cnt_next};
                    run_peak_next = '0;
                    run_sum_next  = '0;
                    run_cnt_next  = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg       <= 1'b0;
            vb_reg       <= 1'b0;
            vc_reg       <= 1'b0;
            run_peak_reg <= '0;
            run_sum_reg  <= '0;
            run_cnt_reg  <= '0;
        end
        else
        begin
            va_reg       <= accept;
            vb_reg       <= va_reg;
            vc_reg       <= vb_reg;
            run_peak_reg <= run_peak_next;
            run_sum_reg  <= run_sum_next;
            run_cnt_reg  <= run_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_item_reg <= item;
        end
        b_op_reg   <= a_item_reg.opcode;
        b_last_reg <= a_item_reg.last_of_buffer;
        b_mag_reg  <= gained;
        c_op_reg   <= b_op_reg;
        c_last_reg <= b_last_reg;
        c_mag_reg  <= b_mag_reg;
        c_sq_reg   <= square[SQ_W-1:0];
    end

endmodule

### hw/rtl/aprlm_queue.sv
// ----------------------------------------------------------------------------
// aprlm_queue
// short job queue between the front and back ends
// ----------------------------------------------------------------------------
module aprlm_queue
    import aprlm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH,
    parameter int WIDTH = 8,
    parameter int LVL_W = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wdata,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rdata,
    output logic             empty,
    output logic [LVL_W-1:0] level
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg;
    logic             do_rd;

    assign empty = (level_reg == '0);
    assign level = level_reg;
    assign rdata = rdata_reg;
    assign do_rd = rd_en && !empty;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            rd_ptr_reg <= rd_ptr_next;
            if (wr_en && !do_rd)
            begin
                level_reg <= level_reg + 1'b1;
            end
            else if (do_rd && !wr_en)
            begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

    // head entry kept in a register, new request forwarded when it lands there
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
        if (wr_en && (wr_ptr_reg == rd_ptr_next))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[rd_ptr_next];
        end
    end

endmodule

### hw/rtl/aprlm_back.sv
// ----------------------------------------------------------------------------
// aprlm_back
// buffer close (serial divide, serial square root, level update) and
// report generation into a one-entry result register
// ----------------------------------------------------------------------------
module aprlm_back
    import aprlm_pkg::*;
#(
    parameter int MAX_BUFFER_SAMPLES = MAX_BUFFER_SAMPLES_DEFAULT,
    parameter int CNT_W              = $clog2(MAX_BUFFER_SAMPLES + 1),
    parameter int SUM_W              = 2 * (SAMPLE_BITS - 1) + 1 + CNT_W,
    parameter int JOB_W              = 1 + LEVEL_W + SUM_W + CNT_W
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  logic [JOB_W-1:0]  q_rdata,
    output logic              q_pop,
    input  logic [CHAN_W-1:0] channel_count,
    output logic              empty,
    input  logic              pop,
    output report_t           result
);

    localparam int RAD_W  = SUM_W + (SUM_W % 2);
    localparam int ROOT_W = RAD_W / 2;
    localparam int SREM_W = ROOT_W + 2;
    localparam int STEP_W = $clog2(SUM_W + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_SQRT = 4'b0100,
        S_EMIT = 4'b1000
    } back_state_t;

    back_state_t        state_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [SUM_W-1:0]   dq_reg;
    logic [CNT_W-1:0]   drem_reg, divisor_reg;
    logic [RAD_W-1:0]   rad_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [SREM_W-1:0]  srem_reg;
    logic [LEVEL_W-1:0] job_peak_reg;
    logic [LEVEL_W-1:0] lbp_reg, lbr_reg, psr_reg, hold_reg;
    logic [FRAME_W-1:0] frames_reg;
    logic               out_valid_reg;
    report_t            out_reg;

    logic               job_kind;
    logic [LEVEL_W-1:0] job_peak;
    logic [SUM_W-1:0]   job_sum;
    logic [CNT_W-1:0]   job_cnt;
    logic               slot_free;
    logic               out_load;
    logic [CNT_W:0]     div_sh, div_diff;
    logic               div_ge;
    logic [SREM_W-1:0]  sq_sh, sq_trial;
    logic               sq_ge;
    logic [CNT_W-1:0]   frames;
    report_t            report_now;

    assign {job_kind, job_peak, job_sum, job_cnt} = q_rdata;
    assign slot_free = !out_valid_reg || pop;
    assign empty     = !out_valid_reg;
    assign result    = out_reg;

    assign div_sh   = {drem_reg, dq_reg[SUM_W-1]};
    assign div_diff = div_sh - {1'b0, divisor_reg};
    assign div_ge   = div_sh >= {1'b0, divisor_reg};

    assign sq_sh    = {srem_reg[SREM_W-3:0], rad_reg[RAD_W-1:RAD_W-2]};
    assign sq_trial = {root_reg, 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;

    assign frames = (channel_count == CH_STEREO) ? (divisor_reg >> 1) : divisor_reg;

    always_comb
    begin
        report_now.report_kind   = (state_reg == S_EMIT) ? KIND_UPDATE : KIND_READ;
        report_now.current_peak  = lbp_reg;
        report_now.current_rms   = lbr_reg;
        report_now.interval_peak = (psr_reg != '0) ? psr_reg : lbp_reg;
        report_now.held_peak     = hold_reg;
        report_now.frame_total   = frames_reg;
    end

    always_comb
    begin
        q_pop = 1'b0;
        if (state_reg == S_IDLE && !q_empty)
        begin
            q_pop = (job_kind == KIND_UPDATE) || slot_free;
        end
    end

    assign out_load = ((state_reg == S_IDLE) && q_pop && (job_kind == KIND_READ))
                   || ((state_reg == S_EMIT) && slot_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            lbp_reg       <= '0;
            lbr_reg       <= '0;
            psr_reg       <= '0;
            hold_reg      <= '0;
            frames_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        if (job_kind == KIND_READ)
                        begin
                            psr_reg <= '0;
                        end
                        else
                        begin
                            step_reg  <= STEP_W'(SUM_W - 1);
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV:
                begin
                    if (step_reg == '0)
                    begin
                        step_reg  <= STEP_W'(ROOT_W - 1);
                        state_reg <= S_SQRT;
                    end
                    else
                    begin
                        step_reg <= step_reg - 1'b1;
                    end
                end
                S_SQRT:
                begin
                    if (step_reg == '0)
                    begin
                        lbp_reg    <= job_peak_reg;
                        lbr_reg    <= LEVEL_W'({root_reg[ROOT_W-2:0], sq_ge});
                        psr_reg    <= (job_peak_reg > psr_reg) ? job_peak_reg : psr_reg;
                        hold_reg   <= (job_peak_reg > hold_reg) ? job_peak_reg : hold_reg;
                        frames_reg <= frames_reg + FRAME_W'(frames);
                        state_reg  <= S_EMIT;
                    end
                    else
                    begin
                        step_reg <= step_reg - 1'b1;
                    end
                end
                S_EMIT:
                begin
                    if (slot_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= report_now;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    dq_reg       <= job_sum;
                    divisor_reg  <= job_cnt;
                    job_peak_reg <= job_peak;
                    drem_reg     <= '0;
                end
            end
            S_DIV:
            begin
                drem_reg <= div_ge ? div_diff[CNT_W-1:0] : div_sh[CNT_W-1:0];
                dq_reg   <= {dq_reg[SUM_W-2:0], div_ge};
                if (step_reg == '0)
                begin
                    rad_reg  <= RAD_W'({dq_reg[SUM_W-2:0], div_ge});
                    root_reg <= '0;
                    srem_reg <= '0;
                end
            end
            S_SQRT:
            begin
                srem_reg <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
                root_reg <= {root_reg[ROOT_W-2:0], sq_ge};
                rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            end
            S_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

endmodule

### hw/rtl/audio_peak_rms_level_meter.sv
// ----------------------------------------------------------------------------
// audio_peak_rms_level_meter
// gained audio level meter: buffer peak and rms, interval and held peak,
// frame total
// ----------------------------------------------------------------------------
// usage:
//   input queue (push / full, item): audio samples and level read requests
//   result queue (empty / pop, result): one report per closed buffer and per
//   read request, in request order
//   apb port: channel_count at 0x0, input_gain at 0x4, write in access phase
// throughput: samples enter one per cycle through a three-stage gain and
//   square pipeline; full rises while the eight-entry job queue plus the
//   requests in that pipeline could fill it
// back end: a read request passes the gain and square pipeline and the job
//   queue, and its report is loaded into the result register when the back
//   end is idle; a buffer close runs the one-bit-a-cycle divider and the
//   two-bits-a-cycle square root in the back end, one close at a time
// reset: all levels and counts clear, channel_count 1, input_gain 4096
// stall: a report waits in the result register while pop is low; the back
//   end then holds, the job queue fills and full rises
// ----------------------------------------------------------------------------
module audio_peak_rms_level_meter
    import aprlm_pkg::*;
#(
    parameter int MAX_BUFFER_SAMPLES = MAX_BUFFER_SAMPLES_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  in_item_t              item,
    output logic                  empty,
    input  logic                  pop,
    output report_t               result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CNT_W = $clog2(MAX_BUFFER_SAMPLES + 1);
    localparam int SUM_W = 2 * (SAMPLE_BITS - 1) + 1 + CNT_W;
    localparam int JOB_W = 1 + LEVEL_W + SUM_W + CNT_W;
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    logic [CHAN_W-1:0]    channel_count_reg;
    logic [GAIN_W-1:0]    input_gain_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;

    logic             q_push, q_pop, q_empty;
    logic [JOB_W-1:0] q_wdata, q_rdata;
    logic [LVL_W-1:0] q_level;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[CFG_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (reg_idx)
            REG_CHANNEL_COUNT: prdata = CFG_DATA_W'(channel_count_reg);
            REG_INPUT_GAIN:    prdata = CFG_DATA_W'(input_gain_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= CHANNEL_COUNT_RESET;
            input_gain_reg    <= INPUT_GAIN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_CHANNEL_COUNT: channel_count_reg <= pwdata[CHAN_W-1:0];
                REG_INPUT_GAIN:    input_gain_reg    <= pwdata[GAIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    aprlm_front #(
        .MAX_BUFFER_SAMPLES (MAX_BUFFER_SAMPLES),
        .CNT_W              (CNT_W),
        .SUM_W              (SUM_W),
        .JOB_W              (JOB_W),
        .LVL_W              (LVL_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .input_gain (input_gain_reg),
        .q_level    (q_level),
        .q_push     (q_push),
        .q_wdata    (q_wdata)
    );

    aprlm_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (JOB_W),
        .LVL_W (LVL_W)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (q_push),
        .wdata (q_wdata),
        .rd_en (q_pop),
        .rdata (q_rdata),
        .empty (q_empty),
        .level (q_level)
    );

    aprlm_back #(
        .MAX_BUFFER_SAMPLES (MAX_BUFFER_SAMPLES),
        .CNT_W              (CNT_W),
        .SUM_W              (SUM_W),
        .JOB_W              (JOB_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_rdata       (q_rdata),
        .q_pop         (q_pop),
        .channel_count (channel_count_reg),
        .empty         (empty),
        .pop           (pop),
        .result        (result)
    );

endmodule
